### hw/rtl/egd_pkg.sv
// ----------------------------------------------------------------------------
// Exp-Golomb decoder package
// Shared beat types, status codes and fixed sizes of the unsigned Exp-Golomb
// decoder.
// ----------------------------------------------------------------------------
package egd_pkg;

  // Bits decoded from one stream byte, and so the most results one byte gives.
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned MaxResults  = BitsPerByte;
  localparam int unsigned CountW      = $clog2(MaxResults + 1);
  localparam int unsigned IdxW        = $clog2(MaxResults);
  localparam int unsigned ZeroCountW  = 6;

  typedef enum logic [1:0] {
    EGD_OK    = 2'd0,
    EGD_LONG  = 2'd1,
    EGD_TRUNC = 2'd2
  } egd_status_e;

  // Input beat.
  typedef struct packed {
    logic [BitsPerByte-1:0] data_byte;
    logic                   flush;
  } egd_in_t;

  // Output beat.
  typedef struct packed {
    logic [31:0] code_value;
    egd_status_e status;
    logic        last;
  } egd_out_t;

  // Control part of the decoder state; the suffix accumulator travels apart
  // because its width follows the value width.
  typedef struct packed {
    logic [ZeroCountW-1:0] zero_count;
    logic                  in_suffix;
    logic [ZeroCountW-1:0] suffix_left;
  } egd_ctl_t;

endpackage

### hw/rtl/egd_decode.sv
// ----------------------------------------------------------------------------
// Exp-Golomb byte decoder
// Combinational decode of one stream byte: walks its eight bits from the most
// significant one, gives the next decoder state and up to eight results.
// ----------------------------------------------------------------------------
module egd_decode import egd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  egd_in_t                beat_i,
  input  egd_ctl_t               ctl_i,
  input  logic [VALUE_WIDTH-1:0] acc_i,
  output egd_ctl_t               ctl_o,
  output logic [VALUE_WIDTH-1:0] acc_o,
  output logic [CountW-1:0]      num_o,
  // Each result carries its code word plus one; the caller subtracts one.
  output logic [VALUE_WIDTH-1:0] raw_o    [MaxResults],
  output egd_status_e            status_o [MaxResults]
);

  localparam logic [VALUE_WIDTH-1:0] One = VALUE_WIDTH'(1);
  localparam logic [ZeroCountW-1:0] ZeroLimit = ZeroCountW'(VALUE_WIDTH);

  always_comb begin
    logic     bit_v;
    egd_ctl_t ctl_v;
    logic [VALUE_WIDTH-1:0] acc_v;
    logic [CountW-1:0]      num_v;
    ctl_v = ctl_i;
    acc_v = acc_i;
    num_v = '0;
    bit_v = 1'b0;
    for (int k = 0; k < MaxResults; k++) begin
      raw_o[k]    = One;
      status_o[k] = EGD_OK;
    end

    if (beat_i.flush) begin
      if (ctl_v.in_suffix || (ctl_v.zero_count != '0)) begin
        status_o[0] = EGD_TRUNC;
        num_v       = CountW'(1);
      end
      ctl_v = '0;
      acc_v = '0;
    end else begin
      for (int i = BitsPerByte - 1; i >= 0; i--) begin
        bit_v = beat_i.data_byte[IdxW'(i)];
        if (!ctl_v.in_suffix) begin
          if (!bit_v) begin
            ctl_v.zero_count = ctl_v.zero_count + 1'b1;
            if (ctl_v.zero_count >= ZeroLimit) begin
              status_o[num_v[IdxW-1:0]] = EGD_LONG;
              num_v = num_v + 1'b1;
              ctl_v.zero_count = '0;
            end
          end else if (ctl_v.zero_count == '0) begin
            // A lone one bit is the code for zero.
            num_v = num_v + 1'b1;
          end else begin
            ctl_v.in_suffix   = 1'b1;
            ctl_v.suffix_left = ctl_v.zero_count;
            acc_v             = One;
          end
        end else begin
          acc_v = {acc_v[VALUE_WIDTH-2:0], bit_v};
          if (ctl_v.suffix_left != '0) begin
            ctl_v.suffix_left = ctl_v.suffix_left - 1'b1;
          end
          if (ctl_v.suffix_left == '0) begin
            raw_o[num_v[IdxW-1:0]] = acc_v;
            num_v = num_v + 1'b1;
            ctl_v = '0;
            acc_v = '0;
          end
        end
      end
    end

    ctl_o = ctl_v;
    acc_o = acc_v;
    num_o = num_v;
  end

endmodule

### hw/rtl/exp_golomb_ue_decoder.sv
// ----------------------------------------------------------------------------
// Unsigned Exp-Golomb decoder
// Decodes back-to-back unsigned Exp-Golomb codes from a byte stream and emits
// one decoded value per output beat.
// ----------------------------------------------------------------------------
// Each input beat carries one stream byte, decoded most significant bit
// first, or a flush that ends the stream. A byte is decoded in the cycle it
// is accepted, in a single combinational pass over its eight bits, and its
// results (none up to eight) are written together into one of two result
// banks. The output side drains a bank one result per beat, with the last
// flag set on the final result that the byte caused. A byte that yields no
// result never touches the banks, and a stream of bytes that each yield at most
// one result runs at one byte per clock while the output does not stall. A byte
// that yields k results holds the output for k beats; because the next byte may
// fill the other bank meanwhile, the input stalls only when both banks hold
// results that are still waiting, so the sustained input rate is set by the
// single output port, which drains one result per beat. A prefix of VALUE_WIDTH
// zeros gives a result with the long-prefix status and value zero, and prefix
// counting restarts. A flush reports a truncated-code result when a code is
// part-way through, then clears the decoder; the byte of a flush beat is not
// decoded. Values are at most 2^VALUE_WIDTH - 2 and sit zero-extended in the
// 32-bit value field; error results carry value zero.
module exp_golomb_ue_decoder import egd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  egd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output egd_out_t out_data_o
);

  // Decoder state.
  egd_ctl_t               ctl_q, ctl_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;

  // Results of the byte being accepted.
  logic [CountW-1:0]      dec_num;
  logic [VALUE_WIDTH-1:0] dec_raw    [MaxResults];
  egd_status_e            dec_status [MaxResults];

  // Two result banks: one may be drained while the other is filled.
  logic [VALUE_WIDTH-1:0] bank_raw_q    [2][MaxResults];
  egd_status_e            bank_status_q [2][MaxResults];
  logic [CountW-1:0]      cnt_q [2];
  logic [CountW-1:0]      cnt_d [2];
  logic                   wr_bank_q, wr_bank_d;
  logic                   rd_bank_q, rd_bank_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;

  logic in_acc;
  logic out_acc;
  logic fill;
  logic last_beat;

  logic [VALUE_WIDTH-1:0] rd_raw;

  egd_decode #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_decode (
    .beat_i   (in_data_i),
    .ctl_i    (ctl_q),
    .acc_i    (acc_q),
    .ctl_o    (ctl_d),
    .acc_o    (acc_d),
    .num_o    (dec_num),
    .raw_o    (dec_raw),
    .status_o (dec_status)
  );

  // The bank being filled must be empty before a new byte can land in it.
  assign in_stall_o = (cnt_q[wr_bank_q] != '0);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fill       = in_acc && (dec_num != '0);

  assign out_valid_o = (cnt_q[rd_bank_q] != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign last_beat   = ({1'b0, rd_idx_q} == (cnt_q[rd_bank_q] - 1'b1));

  // Stored words are the code plus one, so every result subtracts one here;
  // error results are stored as one and come out as zero.
  assign rd_raw = bank_raw_q[rd_bank_q][rd_idx_q] - VALUE_WIDTH'(1);

  always_comb begin
    out_data_o.code_value = 32'(rd_raw);
    out_data_o.status     = bank_status_q[rd_bank_q][rd_idx_q];
    out_data_o.last       = last_beat;
  end

  // Bank bookkeeping. A bank is filled only while empty and drained only
  // while it holds results, so the two updates never touch the same count.
  always_comb begin
    cnt_d     = cnt_q;
    wr_bank_d = wr_bank_q;
    rd_bank_d = rd_bank_q;
    rd_idx_d  = rd_idx_q;
    if (fill) begin
      cnt_d[wr_bank_q] = dec_num;
      wr_bank_d        = ~wr_bank_q;
    end
    if (out_acc) begin
      if (last_beat) begin
        cnt_d[rd_bank_q] = '0;
        rd_bank_d        = ~rd_bank_q;
        rd_idx_d         = '0;
      end else begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q     <= '0;
      acc_q     <= '0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      wr_bank_q <= 1'b0;
      rd_bank_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (in_acc) begin
        ctl_q <= ctl_d;
        acc_q <= acc_d;
      end
      cnt_q     <= cnt_d;
      wr_bank_q <= wr_bank_d;
      rd_bank_q <= rd_bank_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  // Result payload needs no reset: the counts say which entries are live.
  always_ff @(posedge clk_i) begin
    if (fill) begin
      for (int k = 0; k < MaxResults; k++) begin
        bank_raw_q[wr_bank_q][k]    <= dec_raw[k];
        bank_status_q[wr_bank_q][k] <= dec_status[k];
      end
    end
  end

  // A byte that yields results must show a result on the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill |=> out_valid_o)
    else $error("decoded results did not reach the output");

  // With both banks occupied the fill and drain pointers must meet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q[0] != '0) && (cnt_q[1] != '0)) |-> (wr_bank_q == rd_bank_q))
    else $error("bank pointers out of step");

  // A bank never holds more results than one byte can give.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CountW'(MaxResults)) && (cnt_q[1] <= CountW'(MaxResults)))
    else $error("bank count beyond its depth");

  // When both banks are empty the read side must point at the fill side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q[0] == '0) && (cnt_q[1] == '0)) |-> (wr_bank_q == rd_bank_q && rd_idx_q == '0))
    else $error("idle decoder with stale read position");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Exp-Golomb decoder testbench
// Streams bytes and flush beats into the unsigned Exp-Golomb decoder with
// random gaps and output stalls. A scoreboard predicts every decoded value
// and status bit for bit and checks each output beat in order.
// ----------------------------------------------------------------------------

import egd_pkg::*;

// Keeps its own copy of the decoder state, expands each accepted input beat
// into the results it should cause, and compares output beats in order.
class egd_scoreboard;
  localparam int unsigned ValueWidth = 32;

  egd_out_t    pending_q[$];
  logic [5:0]  zero_cnt;
  bit          in_sfx;
  logic [5:0]  sfx_left;
  logic [63:0] sfx_acc;
  int unsigned errors;
  int unsigned ok_seen;
  int unsigned long_seen;
  int unsigned trunc_seen;

  function new();
    clear_code();
    errors     = 0;
    ok_seen    = 0;
    long_seen  = 0;
    trunc_seen = 0;
  endfunction

  function void clear_code();
    zero_cnt = '0;
    in_sfx   = 1'b0;
    sfx_left = '0;
    sfx_acc  = '0;
  endfunction

  function void push_result(logic [63:0] value, egd_status_e st);
    egd_out_t r;
    r.code_value = value[31:0];
    r.status     = st;
    r.last       = 1'b0;
    pending_q.push_back(r);
  endfunction

  function int unsigned outstanding();
    return pending_q.size();
  endfunction

  // Decode one accepted input beat into the results it must produce.
  function void note_input(egd_in_t beat);
    logic [63:0] mask;
    int unsigned before_n;
    int          i;
    bit          b;
    egd_out_t    tail;
    mask     = (64'd1 << ValueWidth) - 64'd1;
    before_n = pending_q.size();
    if (beat.flush) begin
      if (in_sfx || zero_cnt != 0) push_result('0, EGD_TRUNC);
      clear_code();
    end else begin
      for (i = BitsPerByte - 1; i >= 0; i--) begin
        b = beat.data_byte[i];
        if (!in_sfx) begin
          if (!b) begin
            zero_cnt++;
            if (zero_cnt >= ValueWidth) begin
              push_result('0, EGD_LONG);
              zero_cnt = '0;
            end
          end else if (zero_cnt == 0) begin
            push_result('0, EGD_OK);
          end else begin
            in_sfx   = 1'b1;
            sfx_left = zero_cnt;
            sfx_acc  = 64'd1;
          end
        end else begin
          sfx_acc = ((sfx_acc << 1) | 64'(b)) & mask;
          if (sfx_left > 0) sfx_left--;
          if (sfx_left == 0) begin
            push_result((sfx_acc - 64'd1) & mask, EGD_OK);
            clear_code();
          end
        end
      end
    end
    if (pending_q.size() > before_n) begin
      tail      = pending_q.pop_back();
      tail.last = 1'b1;
      pending_q.push_back(tail);
    end
  endfunction

  task report(string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  task check_result(egd_out_t got);
    egd_out_t want;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result value %h status %0d last %0b",
                       got.code_value, got.status, got.last));
      return;
    end
    want = pending_q.pop_front();
    case (want.status)
      EGD_OK:    ok_seen++;
      EGD_LONG:  long_seen++;
      EGD_TRUNC: trunc_seen++;
      default:   ;
    endcase
    if (got.code_value !== want.code_value)
      report($sformatf("code_value %h, wanted %h", got.code_value, want.code_value));
    if (got.status !== want.status)
      report($sformatf("status %0d, wanted %0d", got.status, want.status));
    if (got.last !== want.last)
      report($sformatf("last %0b, wanted %0b", got.last, want.last));
  endtask

  task check_drained();
    if (pending_q.size() != 0)
      report($sformatf("%0d results never arrived", pending_q.size()));
  endtask
endclass

module testbench;

  // Random part of the stimulus, the output hold-off used to back the block
  // up, the settling time at the end and the watchdog limit.
  localparam int unsigned RandomBeats = 100;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_valid   = 1'b0;
  egd_in_t  in_data    = '0;
  logic     out_stall  = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  egd_out_t out_data_o;

  egd_scoreboard sb;

  // Stream bits still waiting to be packed into bytes by the random part.
  bit          stream_bits[$];
  int unsigned beats_sent   = 0;
  int unsigned flushes_sent = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_cycles = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  bit          burst_mode   = 1'b0;
  bit          hold_req     = 1'b0;

  exp_golomb_ue_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Single observation point for both channels. Everything the testbench
  // drives changes by nonblocking assignment at the rising edge, so at this
  // point every signal still holds the value it had just before the edge.
  // Noting inputs before checking outputs keeps the order fixed even if a
  // result ever left in the same cycle as the beat that caused it.
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count++;
      if (in_valid && in_stall_o === 1'b0) sb.note_input(in_data);
      if (in_valid && in_stall_o === 1'b1) stall_cycles++;
      if (out_valid_o === 1'b1 && out_stall === 1'b0) sb.check_result(out_data_o);
    end
  end

  // Watchdog: a run that has not finished well beyond its slowest correct
  // length is taken to be hung.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timed out after %0d cycles.", cycle_count);
    $display("FAIL");
    $finish;
  end

  // Offers one input beat after a random gap and returns at the edge where
  // it is taken. With no gap the valid simply stays high for the next beat.
  task automatic send_beat(egd_in_t beat);
    int unsigned gap;
    gap = (tx_idle_on && !burst_mode) ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    beats_sent++;
    if (beat.flush) flushes_sent++;
    if (beats_sent % 16 == 0) tx_idle_on = 1'($urandom_range(0, 1));
  endtask

  task automatic send_byte(logic [7:0] data);
    egd_in_t beat;
    beat.data_byte = data;
    beat.flush     = 1'b0;
    send_beat(beat);
  endtask

  // The byte of a flush beat is carried along but must be ignored.
  task automatic send_flush(logic [7:0] data);
    egd_in_t beat;
    beat.data_byte = data;
    beat.flush     = 1'b1;
    send_beat(beat);
  endtask

  // Appends one well-formed code with the given prefix length and a random
  // suffix to the pending bit stream.
  task automatic push_code(int unsigned zeros);
    int unsigned k;
    repeat (zeros) stream_bits.push_back(1'b0);
    stream_bits.push_back(1'b1);
    for (k = 0; k < zeros; k++) stream_bits.push_back(bit'($urandom_range(0, 1)));
  endtask

  task automatic pack_stream_bits();
    logic [7:0] data;
    int         i;
    while (stream_bits.size() >= 8) begin
      for (i = 7; i >= 0; i--) data[i] = stream_bits.pop_front();
      send_byte(data);
    end
  endtask

  // Hand-picked beats: the one-bit code, a full byte of them, the longest
  // legal code with an all-ones suffix, a prefix that runs too long, flushes
  // with and without a pending code, and a flush carrying a nonzero byte.
  task automatic run_directed();
    send_flush(8'h00);                 // nothing pending, so no result
    send_byte(8'hff);                  // eight one-bit codes, value zero each
    send_byte(8'h80);                  // one-bit code, then seven zeros
    send_byte(8'h80);                  // seven-bit suffix completes: 127
    repeat (4) send_byte(8'h00);       // thirty-two zeros: prefix too long
    repeat (3) send_byte(8'h00);       // thirty-one zeros then the one bit
    send_byte(8'h01);
    repeat (3) send_byte(8'hff);       // all-ones suffix, largest value
    send_byte(8'hfe);                  // finishes it and opens a new prefix
    send_flush(8'hff);                 // prefix pending: truncated
    send_byte(8'h40);                  // value one, then five zeros
    send_byte(8'ha5);                  // suffix completes (40), leaves a partial
    send_flush(8'h00);                 // suffix pending: truncated
    send_flush(8'h5a);                 // already clear: no result
    send_byte(8'h55);                  // four short codes in one byte
    send_byte(8'h7f);                  // value two, then five zero values
    send_byte(8'h00);
    send_flush(8'h00);
  endtask

  // Mostly well-formed streams of random codes, with prefixes over the limit,
  // stray bytes that break the code sequence, and flushes mixed in.
  task automatic run_random();
    int unsigned first_beat;
    int unsigned pick;
    int unsigned kind;
    first_beat = beats_sent;
    while (beats_sent - first_beat < RandomBeats) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        kind = $urandom_range(0, 9);
        if (kind < 6)      push_code($urandom_range(0, 3));
        else if (kind < 8) push_code($urandom_range(4, 12));
        else               push_code($urandom_range(13, 31));
      end else if (pick < 78) begin
        repeat ($urandom_range(32, 40)) stream_bits.push_back(1'b0);
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // Pad to a whole byte so that the flush lands after every code bit.
        while (stream_bits.size() % 8 != 0) stream_bits.push_back(bit'($urandom_range(0, 1)));
        pack_stream_bits();
        send_flush(8'($urandom_range(0, 255)));
      end
      pack_stream_bits();
    end
  endtask

  // Output side. Each beat is preceded by a random stall; on request it
  // instead holds off for a long stretch so that both result banks fill and
  // the block has to stall its input.
  initial begin
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        gap      = HoldCycles;
        hold_req = 1'b0;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 7) : 0;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid_o !== 1'b1);
      taken++;
      if (taken % 12 == 0) rx_idle_on = 1'($urandom_range(0, 1));
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Back-to-back bytes that each yield eight results while the output
    // side is held off: the input has to stall until it drains.
    hold_req   = 1'b1;
    burst_mode = 1'b1;
    repeat (6) send_byte(8'hff);
    burst_mode = 1'b0;

    run_random();
    in_valid <= 1'b0;

    // One more edge so that the final accepted beat has surely been noted.
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    sb.check_drained();

    $display("Sent %0d input beats (%0d flushes); the input stalled for %0d cycles.",
             beats_sent, flushes_sent, stall_cycles);
    $display("Checked %0d decoded values, %0d long-prefix and %0d truncated results.",
             sb.ok_seen, sb.long_seen, sb.trunc_seen);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
